@@ rtl/omp_pkg.sv @@
package omp_pkg;

    // Capacity of the type tag store.
    localparam int MAX_TAGS = 16;
    // Counter width for a tag count or parameter index, 0 up to MAX_TAGS.
    localparam int CNT_W = $clog2(MAX_TAGS + 1);
    // Index width into the tag store.
    localparam int TAG_AW = (MAX_TAGS > 1) ? $clog2(MAX_TAGS) : 1;

    // Token queue between the parser and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Token kinds.
    localparam logic [2:0] K_ADDR_BYTE = 3'd0;
    localparam logic [2:0] K_ADDR_END  = 3'd1;
    localparam logic [2:0] K_INT       = 3'd2;
    localparam logic [2:0] K_FLOAT     = 3'd3;
    localparam logic [2:0] K_STR_BYTE  = 3'd4;
    localparam logic [2:0] K_STR_END   = 3'd5;
    localparam logic [2:0] K_DONE      = 3'd6;
    localparam logic [2:0] K_ERROR     = 3'd7;

    // Error codes.
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_NO_COMMA = 3'd1;
    localparam logic [2:0] E_TRUNC    = 3'd2;
    localparam logic [2:0] E_UNKNOWN  = 3'd3;
    localparam logic [2:0] E_TOO_MANY = 3'd4;

    // Characters of the type tag string.
    localparam logic [7:0] CHAR_I     = 8'h69;
    localparam logic [7:0] CHAR_F     = 8'h66;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    // Parser phases.
    typedef enum logic [3:0] {
        PH_ADDR,
        PH_ADDR_PAD,
        PH_TAG_FIRST,
        PH_TAGS,
        PH_TAG_PAD,
        PH_WORD,
        PH_STR,
        PH_STR_PAD,
        PH_SKIP
    } t_phase;

    // Decoded type tag, as held in the tag store.
    typedef enum logic [1:0] {
        TC_INT,
        TC_FLOAT,
        TC_STR,
        TC_UNKNOWN
    } t_tag_class;

    // One input beat.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } t_in_beat;

    // One output beat (one token).
    typedef struct packed {
        logic [2:0]  token_kind;
        logic [3:0]  param_number;
        logic [31:0] token_value;
        logic [2:0]  error_code;
        logic        last_of_message;
    } t_out_beat;

    // Tokens caused by one input byte: one, or two when two is set.
    typedef struct packed {
        logic      two;
        t_out_beat tok0;
        t_out_beat tok1;
    } t_pair;

endpackage

@@ rtl/osc_message_parser.sv @@
// OSC message parser. Each input beat is one datagram byte, with end_of_datagram on the last
// byte; each output beat is one token (address byte or end, int or float word, string byte or
// end, and a final done or error token flagged last_of_message). The parser takes one byte per
// clock and writes the zero, one or two tokens it causes as one entry into a four-entry queue;
// the output register drains one token per clock while i_ready is high. A byte that causes two
// tokens is drained from its queue entry one token at a time, and the input stalls only when the
// queue is full. The first token of a byte is registered in the queue and then in the output
// register before it appears at the output.
module osc_message_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  omp_pkg::t_in_beat  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output omp_pkg::t_out_beat o_data
);
    import omp_pkg::*;

    logic  push;
    logic  full;
    logic  q_valid;
    logic  pop;
    t_pair push_pair;
    t_pair head_pair;

    // Byte parser.
    omp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (push),
        .o_pair  (push_pair),
        .i_full  (full)
    );

    // Token queue.
    omp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pair  (push_pair),
        .o_full  (full),
        .o_valid (q_valid),
        .o_pair  (head_pair),
        .i_pop   (pop)
    );

    // Output stage.
    omp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_pair  (head_pair),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_ready (i_ready)
    );

endmodule

@@ rtl/omp_front.sv @@
module omp_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  omp_pkg::t_in_beat i_data,
    output logic             o_push,
    output omp_pkg::t_pair   o_pair,
    input  logic             i_full
);
    import omp_pkg::*;

    t_phase            r_phase, n_phase;
    logic [1:0]        r_align, n_align;
    logic [CNT_W-1:0]  r_tag_count, n_tag_count;
    logic [CNT_W-1:0]  r_cur, n_cur;
    logic [1:0]        r_seen, n_seen;
    logic [23:0]       r_acc, n_acc;
    t_tag_class        r_cur_class, n_cur_class;
    t_tag_class        r_tags [MAX_TAGS];

    logic              accept;
    logic [7:0]        b;
    logic              eod;
    logic [CNT_W-1:0]  rd_cnt;
    t_tag_class        rd_class;
    t_tag_class        wr_class;
    logic              tag_we;
    logic              do_next;
    logic              do_enter;
    logic [1:0]        cnt;
    t_out_beat         tk [2];

    function automatic t_out_beat mk(logic [2:0] k, logic [3:0] p, logic [31:0] v,
                                     logic [2:0] e, logic l);
        t_out_beat t;
        t.token_kind      = k;
        t.param_number    = p;
        t.token_value     = v;
        t.error_code      = e;
        t.last_of_message = l;
        return t;
    endfunction

    assign accept = i_valid && !i_full;
    assign o_ready = !i_full;
    assign b = i_data.data_byte;
    assign eod = i_data.end_of_datagram;

    // The tag store is read at entry 0 when parameters start, else at the next parameter.
    always_comb begin
        if (r_phase inside {PH_TAGS, PH_TAG_PAD}) begin
            rd_cnt = '0;
        end else begin
            rd_cnt = r_cur + 1'b1;
        end
    end
    assign rd_class = r_tags[rd_cnt[TAG_AW-1:0]];

    // Decode an incoming type tag.
    always_comb begin
        case (b)
            CHAR_I:  wr_class = TC_INT;
            CHAR_F:  wr_class = TC_FLOAT;
            CHAR_S:  wr_class = TC_STR;
            default: wr_class = TC_UNKNOWN;
        endcase
    end

    // Parse one byte: next state and the tokens it causes.
    always_comb begin
        n_phase     = r_phase;
        n_align     = r_align + 2'd1;
        n_tag_count = r_tag_count;
        n_cur       = r_cur;
        n_seen      = r_seen;
        n_acc       = r_acc;
        n_cur_class = r_cur_class;
        tag_we      = 1'b0;
        do_next     = 1'b0;
        do_enter    = 1'b0;
        cnt         = 2'd0;
        tk[0]       = '0;
        tk[1]       = '0;

        case (r_phase)
            PH_ADDR: begin
                if (b != 8'd0) begin
                    tk[cnt[0]] = mk(K_ADDR_BYTE, 4'd0, 32'(b), E_NONE, 1'b0);
                    cnt = cnt + 2'd1;
                end else begin
                    tk[cnt[0]] = mk(K_ADDR_END, 4'd0, 32'd0, E_NONE, 1'b0);
                    cnt = cnt + 2'd1;
                    n_phase = (n_align == 2'd0) ? PH_TAG_FIRST : PH_ADDR_PAD;
                end
            end
            PH_ADDR_PAD: begin
                if (n_align == 2'd0) begin
                    n_phase = PH_TAG_FIRST;
                end
            end
            PH_TAG_FIRST: begin
                if (b == CHAR_COMMA) begin
                    n_phase = PH_TAGS;
                    n_tag_count = '0;
                end else begin
                    tk[cnt[0]] = mk(K_ERROR, 4'd0, 32'd0, E_NO_COMMA, 1'b1);
                    cnt = cnt + 2'd1;
                    n_phase = PH_SKIP;
                end
            end
            PH_TAGS: begin
                if (b != 8'd0) begin
                    if (r_tag_count >= CNT_W'(MAX_TAGS)) begin
                        tk[cnt[0]] = mk(K_ERROR, 4'd0, 32'd0, E_TOO_MANY, 1'b1);
                        cnt = cnt + 2'd1;
                        n_phase = PH_SKIP;
                    end else begin
                        tag_we = 1'b1;
                        n_tag_count = r_tag_count + 1'b1;
                    end
                end else if (r_tag_count == '0) begin
                    tk[cnt[0]] = mk(K_DONE, 4'd0, 32'd0, E_NONE, 1'b1);
                    cnt = cnt + 2'd1;
                    n_phase = PH_SKIP;
                end else begin
                    n_phase = PH_TAG_PAD;
                    if (n_align == 2'd0) begin
                        n_cur = '0;
                        n_phase = PH_WORD;
                        do_enter = !eod;
                    end
                end
            end
            PH_TAG_PAD: begin
                if (n_align == 2'd0) begin
                    n_cur = '0;
                    n_phase = PH_WORD;
                    do_enter = !eod;
                end
            end
            PH_WORD: begin
                n_acc = {r_acc[15:0], b};
                n_seen = r_seen + 2'd1;
                if (r_seen == 2'd3) begin
                    tk[cnt[0]] = mk((r_cur_class == TC_FLOAT) ? K_FLOAT : K_INT,
                                    4'(r_cur), {r_acc, b}, E_NONE, 1'b0);
                    cnt = cnt + 2'd1;
                    n_seen = 2'd0;
                    do_next = 1'b1;
                end
            end
            PH_STR: begin
                if (b != 8'd0) begin
                    tk[cnt[0]] = mk(K_STR_BYTE, 4'(r_cur), 32'(b), E_NONE, 1'b0);
                    cnt = cnt + 2'd1;
                end else begin
                    tk[cnt[0]] = mk(K_STR_END, 4'(r_cur), 32'd0, E_NONE, 1'b0);
                    cnt = cnt + 2'd1;
                    if (n_align == 2'd0) begin
                        do_next = 1'b1;
                    end else begin
                        n_phase = PH_STR_PAD;
                    end
                end
            end
            PH_STR_PAD: begin
                if (n_align == 2'd0) begin
                    do_next = 1'b1;
                end
            end
            default: begin
                n_phase = PH_SKIP;
            end
        endcase

        // A parameter has completed: close the message or move to the next one.
        if (do_next) begin
            n_cur = r_cur + 1'b1;
            if (n_cur >= r_tag_count) begin
                tk[cnt[0]] = mk(K_DONE, 4'd0, 32'(r_tag_count), E_NONE, 1'b1);
                cnt = cnt + 2'd1;
                n_phase = PH_SKIP;
            end else begin
                do_enter = 1'b1;
            end
        end

        // Enter a parameter according to its stored tag.
        if (do_enter) begin
            n_seen = 2'd0;
            n_cur_class = rd_class;
            case (rd_class)
                TC_INT, TC_FLOAT: n_phase = PH_WORD;
                TC_STR:           n_phase = PH_STR;
                default: begin
                    tk[cnt[0]] = mk(K_ERROR, 4'(n_cur), 32'd0, E_UNKNOWN, 1'b1);
                    cnt = cnt + 2'd1;
                    n_phase = PH_SKIP;
                end
            endcase
        end

        // The datagram ends: close an open message and start over.
        if (eod) begin
            if (n_phase inside {PH_ADDR, PH_ADDR_PAD, PH_TAG_FIRST} ||
                (n_phase == PH_TAGS && n_tag_count == '0)) begin
                tk[cnt[0]] = mk(K_DONE, 4'd0, 32'd0, E_NONE, 1'b1);
                cnt = cnt + 2'd1;
            end else if (n_phase != PH_SKIP) begin
                tk[cnt[0]] = mk(K_ERROR,
                                (n_phase inside {[PH_WORD:PH_STR_PAD]}) ? 4'(n_cur) : 4'd0,
                                32'd0, E_TRUNC, 1'b1);
                cnt = cnt + 2'd1;
            end
            n_phase     = PH_ADDR;
            n_align     = 2'd0;
            n_tag_count = '0;
            n_cur       = '0;
            n_seen      = 2'd0;
        end
    end

    // Hand the tokens of this byte to the queue.
    assign o_push      = accept && (cnt != 2'd0);
    assign o_pair.two  = cnt[1];
    assign o_pair.tok0 = tk[0];
    assign o_pair.tok1 = tk[1];

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_ADDR;
            r_align     <= 2'd0;
            r_tag_count <= '0;
            r_cur       <= '0;
            r_seen      <= 2'd0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_align     <= n_align;
            r_tag_count <= n_tag_count;
            r_cur       <= n_cur;
            r_seen      <= n_seen;
        end
    end

    // Word assembly and current tag class.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc       <= n_acc;
            r_cur_class <= n_cur_class;
        end
    end

    // Tag store, written once per tag.
    always_ff @(posedge i_clk) begin
        if (accept && tag_we) begin
            r_tags[r_tag_count[TAG_AW-1:0]] <= wr_class;
        end
    end

endmodule

@@ rtl/omp_queue.sv @@
module omp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  omp_pkg::t_pair i_pair,
    output logic           o_full,
    output logic           o_valid,
    output omp_pkg::t_pair o_pair,
    input  logic           i_pop
);
    import omp_pkg::*;

    t_pair             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_pair  = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_pair;
        end
    end

endmodule

@@ rtl/omp_back.sv @@
module omp_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  omp_pkg::t_pair    i_pair,
    output logic              o_pop,
    output logic              o_valid,
    output omp_pkg::t_out_beat o_data,
    input  logic              i_ready
);
    import omp_pkg::*;

    logic      r_valid;
    logic      r_sub;
    t_out_beat r_data;
    logic      load;

    // Load the next token whenever the output register is free or being taken.
    assign load   = i_valid && (!r_valid || i_ready);
    assign o_pop  = load && (r_sub || !i_pair.two);
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // Output valid and the token select within a queue entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sub   <= !r_sub && i_pair.two;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output token register.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_data <= r_sub ? i_pair.tok1 : i_pair.tok0;
        end
    end

endmodule

@@ rtl/omp_checker.sv @@
module omp_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input omp_pkg::t_in_beat  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input omp_pkg::t_out_beat o_data
);
    import omp_pkg::*;

    logic r_msg_start;

    // Track whether the next output beat opens a new message.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_msg_start <= 1'b1;
        end else if (o_valid && i_ready) begin
            r_msg_start <= o_data.last_of_message;
        end
    end

    // Reset empties the output.
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled output beat changed");

    // Every message opens with an address token.
    a_msg_opens_with_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_msg_start |->
            o_data.token_kind == K_ADDR_BYTE || o_data.token_kind == K_ADDR_END)
        else $error("message did not open with an address token");

    // Once a datagram end is taken, a message that opens next still starts with an address token.
    a_eod_next_opens_with_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_data.end_of_datagram |=> !o_valid || r_msg_start == 1'b0
            || o_data.token_kind == K_ADDR_BYTE || o_data.token_kind == K_ADDR_END)
        else $error("message after datagram end did not open with an address token");

endmodule

bind osc_message_parser omp_checker u_omp_checker (.*);
